### hdl/sfc_pkg.sv
// Shared types and constants of the S-box Feistel cipher block.
// Used by the round cell, the top level and the testbench; no dependencies.
package sfc_pkg;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_ENCRYPT     = 2'd0;
    localparam logic [1:0] CMD_DECRYPT     = 2'd1;
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd2;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LEFT_OFFSET  = 1'b0;
    localparam logic CFG_RIGHT_OFFSET = 1'b1;

    // Box select bit, the top address bit of every lookup RAM
    localparam logic BOX_FIRST  = 1'b0;
    localparam logic BOX_SECOND = 1'b1;

    localparam int SBOX_DEPTH = 256;
    localparam int RAM_DEPTH  = 2 * SBOX_DEPTH;

    typedef logic [8:0] box_addr_t;

    // One pipeline slot: an encrypt/decrypt word or a table load
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  idx;
        logic [7:0]  val;
    } slot_t;

    function automatic logic is_load(input slot_t s);
        return (s.cmd == CMD_LOAD_FIRST) || (s.cmd == CMD_LOAD_SECOND);
    endfunction

    // RAM address of a load: box select on top, table index below
    function automatic box_addr_t load_addr(input slot_t s);
        return {((s.cmd == CMD_LOAD_SECOND) ? BOX_SECOND : BOX_FIRST), s.idx};
    endfunction

endpackage

### hdl/sbox_feistel_cipher_64.sv
// S-box Feistel cipher, 64-bit block: one encrypt or decrypt per clock through a chain of
// 2*ROUND_COUNT half-round cells. A word passes the entry register, the stage registers of
// every cell and the output register on its way from input transfer to result: each cell
// runs its six dependent table-lookup steps on its own two-read-port RAM copies, so the
// chain accepts one item per cycle whenever the result side keeps up. Loads (command 2 or 3)
// travel down the same chain and update each RAM copy as they pass it, so every word sees
// exactly the tables loaded before it; loads give no result. The tables are undefined until
// loaded. Write offsets through the cfg port only while no word is in flight; the block
// itself does not enforce this. Depends on sfc_pkg and sfc_cell.
module sbox_feistel_cipher_64 #(
    parameter int ROUND_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // data_word[63:0], table_index[71:64], table_value[79:72]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_word[63:0]
    output logic [0:0]  m_tuser,   // was_decrypt[0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import sfc_pkg::*;

    localparam int CELL_COUNT = 2 * ROUND_COUNT;

    logic [31:0] left_offset_reg;
    logic [31:0] right_offset_reg;
    logic        in_valid_reg;
    slot_t       in_slot_reg;
    slot_t       in_slot_next;
    logic        chain_valid [0:CELL_COUNT];
    slot_t       chain_slot  [0:CELL_COUNT];
    logic        advance;
    logic        last_is_op;
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_dec_reg;
    logic [31:0] res_hi;
    logic [31:0] res_lo;

    // Offset registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_offset_reg  <= '0;
            right_offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index[0])
                CFG_LEFT_OFFSET:  left_offset_reg  <= cfg_wdata;
                CFG_RIGHT_OFFSET: right_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stall only when a result waits and another one arrives at the end of the chain
    assign last_is_op = chain_valid[CELL_COUNT] && !is_load(chain_slot[CELL_COUNT]);
    assign advance    = !(m_valid_reg && !m_tready && last_is_op);
    assign s_tready   = advance;

    // Entry register, whitening added for encrypt
    always_comb begin
        in_slot_next.cmd = s_tuser;
        in_slot_next.hi  = s_tdata[63:32];
        in_slot_next.lo  = s_tdata[31:0];
        in_slot_next.idx = s_tdata[71:64];
        in_slot_next.val = s_tdata[79:72];
        if (s_tuser == CMD_ENCRYPT) begin
            in_slot_next.hi = s_tdata[63:32] + left_offset_reg;
            in_slot_next.lo = s_tdata[31:0] + right_offset_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_slot_reg <= in_slot_next;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_slot[0]  = in_slot_reg;

    // Half-round cells
    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        sfc_cell #(
            .ROUND_COUNT(ROUND_COUNT),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_valid (chain_valid[i]),
            .in_slot  (chain_slot[i]),
            .out_valid(chain_valid[i+1]),
            .out_slot (chain_slot[i+1])
        );
    end

    // Remove whitening after decrypt
    always_comb begin
        res_hi = chain_slot[CELL_COUNT].hi;
        res_lo = chain_slot[CELL_COUNT].lo;
        if (chain_slot[CELL_COUNT].cmd == CMD_DECRYPT) begin
            res_hi = chain_slot[CELL_COUNT].hi - left_offset_reg;
            res_lo = chain_slot[CELL_COUNT].lo - right_offset_reg;
        end
    end

    // Output register: load a new result, drop loads, clear on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && last_is_op) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_is_op) begin
            m_data_reg <= {res_hi, res_lo};
            m_dec_reg  <= (chain_slot[CELL_COUNT].cmd == CMD_DECRYPT);
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_dec_reg;

endmodule

### hdl/sfc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module sfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AddrWidth = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AddrWidth-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [AddrWidth-1:0] rd_addr_a,
    input  logic [AddrWidth-1:0] rd_addr_b,
    output logic [WIDTH-1:0]     rd_data_a,
    output logic [WIDTH-1:0]     rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered reads, held while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### hdl/sfc_cell.sv
// Half-round cell: one mixing function through six lookup steps, then the
// add or subtract into the other half. Depends on sfc_pkg and sfc_ram.
module sfc_cell #(
    parameter int ROUND_COUNT = 8,
    parameter int CELL_INDEX  = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic          in_valid,
    input  sfc_pkg::slot_t in_slot,
    output logic          out_valid,
    output sfc_pkg::slot_t out_slot
);
    import sfc_pkg::*;

    localparam logic       ODD   = CELL_INDEX % 2 == 1;
    localparam logic [7:0] K_ENC = 8'(CELL_INDEX / 2);
    localparam logic [7:0] K_DEC = 8'(ROUND_COUNT - 1 - CELL_INDEX / 2);

    typedef struct packed {
        logic        left;
        logic [7:0]  k;
        logic        pbox;
        logic        qbox;
        logic [31:0] src;
        logic        add;
    } mix_ctl_t;

    // Which mixing function this slot needs here, and on which half
    function automatic mix_ctl_t decode(input slot_t s);
        mix_ctl_t c;
        logic     dec;
        dec    = (s.cmd == CMD_DECRYPT);
        c.left = dec ^ ODD;
        c.k    = dec ? K_DEC : K_ENC;
        c.pbox = c.left ? BOX_FIRST : BOX_SECOND;
        c.qbox = c.left ? BOX_SECOND : BOX_FIRST;
        c.src  = c.left ? s.lo : s.hi;
        c.add  = (c.left == dec);
        return c;
    endfunction

    slot_t     slot_reg  [1:6];
    logic      valid_reg [1:6];
    slot_t     slot_at   [0:6];
    logic      valid_at  [0:6];
    mix_ctl_t  ctl       [0:6];
    logic      wr_en     [1:6];
    box_addr_t wr_addr   [1:6];
    logic [7:0] wr_data  [1:6];

    // Stage view: entry slot followed by the stage registers
    always_comb begin
        slot_at[0]  = in_slot;
        valid_at[0] = in_valid;
        for (int i = 1; i <= 6; i++) begin
            slot_at[i]  = slot_reg[i];
            valid_at[i] = valid_reg[i];
        end
        for (int i = 0; i <= 6; i++) begin
            ctl[i] = decode(slot_at[i]);
        end
        // A load writes each step's RAM as it passes that step
        for (int i = 1; i <= 6; i++) begin
            wr_en[i]   = advance && valid_at[i-1] && is_load(slot_at[i-1]);
            wr_addr[i] = load_addr(slot_at[i-1]);
            wr_data[i] = slot_at[i-1].val;
        end
    end

    // Valid bits advance with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 6; i++) begin
                valid_reg[i] <= 1'b0;
            end
            out_valid <= 1'b0;
        end else if (advance) begin
            for (int i = 1; i <= 6; i++) begin
                valid_reg[i] <= valid_at[i-1];
            end
            out_valid <= valid_at[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 1; i <= 6; i++) begin
                slot_reg[i] <= slot_at[i-1];
            end
        end
    end

    // Step 1: q[x1], q[x3 ^ k]
    logic [7:0] rd1_a, rd1_b;
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram1 (
        .aclk(aclk), .wr_en(wr_en[1]), .wr_addr(wr_addr[1]), .wr_data(wr_data[1]),
        .rd_en(advance),
        .rd_addr_a({ctl[0].qbox, ctl[0].src[15:8]}),
        .rd_addr_b({ctl[0].qbox, ctl[0].src[31:24] ^ ctl[0].k}),
        .rd_data_a(rd1_a), .rd_data_b(rd1_b)
    );

    // Step 2: first p lookups
    logic [7:0] rd2_a, rd2_b;
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram2 (
        .aclk(aclk), .wr_en(wr_en[2]), .wr_addr(wr_addr[2]), .wr_data(wr_data[2]),
        .rd_en(advance),
        .rd_addr_a({ctl[1].pbox, ctl[1].src[7:0] ^ ctl[1].k ^ rd1_a}),
        .rd_addr_b({ctl[1].pbox, ctl[1].src[15:8] ^ ctl[1].k ^ rd1_b}),
        .rd_data_a(rd2_a), .rd_data_b(rd2_b)
    );

    // Form a and b
    logic [7:0] a_next, b_next;
    always_comb begin
        a_next = ctl[2].left ? rd2_a + ctl[2].src[23:16] : rd2_a ^ ctl[2].src[23:16];
        b_next = ctl[2].left ? rd2_b ^ ctl[2].src[7:0] : rd2_b + ctl[2].src[7:0];
    end

    // Step 3: q[a], q[b]
    logic [7:0] rd3_a, rd3_b;
    logic [7:0] a_s3_reg, b_s3_reg;
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram3 (
        .aclk(aclk), .wr_en(wr_en[3]), .wr_addr(wr_addr[3]), .wr_data(wr_data[3]),
        .rd_en(advance),
        .rd_addr_a({ctl[2].qbox, a_next}),
        .rd_addr_b({ctl[2].qbox, b_next}),
        .rd_data_a(rd3_a), .rd_data_b(rd3_b)
    );

    // Step 4: p lookups for c and d
    logic [7:0] rd4_a, rd4_b;
    logic [7:0] a_s4_reg, b_s4_reg, qa_s4_reg, qb_s4_reg;
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram4 (
        .aclk(aclk), .wr_en(wr_en[4]), .wr_addr(wr_addr[4]), .wr_data(wr_data[4]),
        .rd_en(advance),
        .rd_addr_a({ctl[3].pbox, ctl[3].src[23:16] ^ ctl[3].k ^ rd3_a}),
        .rd_addr_b({ctl[3].pbox, ctl[3].src[31:24] ^ ctl[3].k ^ rd3_b}),
        .rd_data_a(rd4_a), .rd_data_b(rd4_b)
    );

    // Form c, then d from c
    logic [7:0] c_next, d_next;
    always_comb begin
        c_next = ctl[4].left ? rd4_a - ctl[4].src[15:8] : rd4_a ^ ctl[4].src[15:8];
        d_next = ctl[4].left ? rd4_b ^ c_next : rd4_b - c_next;
    end

    // Step 5: q[d], q[c]
    logic [7:0] rd5_a, rd5_b;
    logic [7:0] a_s5_reg, b_s5_reg, c_s5_reg, d_s5_reg, qa_s5_reg, qb_s5_reg;
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram5 (
        .aclk(aclk), .wr_en(wr_en[5]), .wr_addr(wr_addr[5]), .wr_data(wr_data[5]),
        .rd_en(advance),
        .rd_addr_a({ctl[4].qbox, d_next}),
        .rd_addr_b({ctl[4].qbox, c_next}),
        .rd_data_a(rd5_a), .rd_data_b(rd5_b)
    );

    // Step 6: four final p lookups over two RAM copies
    logic [7:0] rd6a_a, rd6a_b, rd6b_a, rd6b_b;
    logic [7:0] a_s6_reg, b_s6_reg, c_s6_reg, d_s6_reg;
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram6a (
        .aclk(aclk), .wr_en(wr_en[6]), .wr_addr(wr_addr[6]), .wr_data(wr_data[6]),
        .rd_en(advance),
        .rd_addr_a({ctl[5].pbox, d_s5_reg ^ qb_s5_reg}),
        .rd_addr_b({ctl[5].pbox, c_s5_reg ^ qa_s5_reg}),
        .rd_data_a(rd6a_a), .rd_data_b(rd6a_b)
    );
    sfc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram6b (
        .aclk(aclk), .wr_en(wr_en[6]), .wr_addr(wr_addr[6]), .wr_data(wr_data[6]),
        .rd_en(advance),
        .rd_addr_a({ctl[5].pbox, b_s5_reg ^ rd5_a}),
        .rd_addr_b({ctl[5].pbox, a_s5_reg ^ rd5_b}),
        .rd_data_a(rd6b_a), .rd_data_b(rd6b_b)
    );

    // Carry the intermediate bytes beside their slot
    always_ff @(posedge aclk) begin
        if (advance) begin
            a_s3_reg  <= a_next;
            b_s3_reg  <= b_next;
            a_s4_reg  <= a_s3_reg;
            b_s4_reg  <= b_s3_reg;
            qa_s4_reg <= rd3_a;
            qb_s4_reg <= rd3_b;
            a_s5_reg  <= a_s4_reg;
            b_s5_reg  <= b_s4_reg;
            c_s5_reg  <= c_next;
            d_s5_reg  <= d_next;
            qa_s5_reg <= qa_s4_reg;
            qb_s5_reg <= qb_s4_reg;
            a_s6_reg  <= a_s5_reg;
            b_s6_reg  <= b_s5_reg;
            c_s6_reg  <= c_s5_reg;
            d_s6_reg  <= d_s5_reg;
        end
    end

    // Pack the mix word and fold it into the other half
    logic [31:0] mix;
    logic [31:0] dst;
    logic [31:0] dst_next;
    slot_t       out_slot_next;
    always_comb begin
        mix      = {rd6b_b ^ d_s6_reg, rd6b_a ^ c_s6_reg,
                    rd6a_b ^ b_s6_reg, rd6a_a ^ a_s6_reg};
        dst      = ctl[6].left ? slot_at[6].hi : slot_at[6].lo;
        dst_next = ctl[6].add ? dst + mix : dst - mix;
        out_slot_next = slot_at[6];
        if (ctl[6].left) begin
            out_slot_next.hi = dst_next;
        end else begin
            out_slot_next.lo = dst_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_slot <= out_slot_next;
        end
    end

endmodule

### hdl/sfc_checker.sv
// Port-level checks for sbox_feistel_cipher_64, attached by the bind below.
// Depends only on the top level's ports.
module sfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [79:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_we,
    input logic [0:0]  cfg_index,
    input logic [31:0] cfg_wdata
);

    // A held result stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // A held result keeps its payload
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // Input side never waits on an empty or draining output
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output can move");

endmodule

bind sbox_feistel_cipher_64 sfc_checker u_sfc_checker (.*);

### tb/tb_sbox_feistel_cipher_64.sv
// Testbench for sbox_feistel_cipher_64: table loads, encrypt and decrypt words
// checked against a cycle-free predictor of the cipher. Depends on sfc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_sbox_feistel_cipher_64;
    import sfc_pkg::*;

    localparam int ROUNDS      = 8;
    localparam int PIPE_DRAIN  = 150;   // longer than a word's path through the chain
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 114;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] word;
        logic [7:0]  idx;
        logic [7:0]  val;
    } cipher_req_t;

    typedef struct packed {
        logic [63:0] word;
        logic        dec;
    } cipher_out_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;    // data_word[63:0], table_index[71:64], table_value[79:72]
    logic [1:0]  s_tuser   = '0;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;           // result_word[63:0]
    logic [0:0]  m_tuser;           // was_decrypt[0]
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    sbox_feistel_cipher_64 #(.ROUND_COUNT(ROUNDS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Predictor state: shadow tables and whitening words
    logic [7:0]  box_first  [SBOX_DEPTH];
    logic [7:0]  box_second [SBOX_DEPTH];
    logic [31:0] left_off  = '0;
    logic [31:0] right_off = '0;

    cipher_req_t pending_q[$];
    cipher_out_t result_q[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          in_taken = 1'b0;

    function automatic logic [7:0] look(bit second, logic [7:0] a);
        return second ? box_second[a] : box_first[a];
    endfunction

    // Byte network of one half; rgt selects the mixing folded into the low half
    function automatic logic [31:0] mix_half(bit rgt, int unsigned r, logic [31:0] w);
        logic [7:0] k, x0, x1, x2, x3, a, b, c, d, t;
        k  = r[7:0];
        x0 = w[7:0];
        x1 = w[15:8];
        x2 = w[23:16];
        x3 = w[31:24];
        t = look(rgt, x0 ^ k ^ look(!rgt, x1));
        a = rgt ? (t ^ x2) : (t + x2);
        t = look(rgt, x1 ^ k ^ look(!rgt, x3 ^ k));
        b = rgt ? (t + x0) : (t ^ x0);
        t = look(rgt, x2 ^ k ^ look(!rgt, a));
        c = rgt ? (t ^ x1) : (t - x1);
        t = look(rgt, x3 ^ k ^ look(!rgt, b));
        d = rgt ? (t - c) : (t ^ c);
        return {look(rgt, a ^ look(!rgt, c)) ^ d,
                look(rgt, b ^ look(!rgt, d)) ^ c,
                look(rgt, c ^ look(!rgt, a)) ^ b,
                look(rgt, d ^ look(!rgt, b)) ^ a};
    endfunction

    function automatic logic [63:0] cipher_word(bit dec, logic [63:0] word);
        logic [31:0] hi, lo;
        hi = word[63:32];
        lo = word[31:0];
        if (!dec) begin
            hi = hi + left_off;
            lo = lo + right_off;
            for (int r = 0; r < ROUNDS; r++) begin
                lo = lo + mix_half(1'b1, r, hi);
                hi = hi - mix_half(1'b0, r, lo);
            end
        end else begin
            for (int r = ROUNDS - 1; r >= 0; r--) begin
                hi = hi + mix_half(1'b0, r, lo);
                lo = lo - mix_half(1'b1, r, hi);
            end
            hi = hi - left_off;
            lo = lo - right_off;
        end
        return {hi, lo};
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Input side: update the shadow tables or queue the expected word on each transfer
    // Output side: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        logic [1:0]  c;
        cipher_out_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                c = s_tuser;
                case (c)
                    CMD_LOAD_FIRST:  box_first[s_tdata[71:64]]  = s_tdata[79:72];
                    CMD_LOAD_SECOND: box_second[s_tdata[71:64]] = s_tdata[79:72];
                    default: result_q.push_back('{word: cipher_word(c == CMD_DECRYPT,
                                                                    s_tdata[63:0]),
                                                  dec: (c == CMD_DECRYPT)});
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata !== want.word)
                        report_mismatch($sformatf("result_word %h, expected %h",
                                                  m_tdata, want.word));
                    if (m_tuser[0] !== want.dec)
                        report_mismatch($sformatf("was_decrypt %b, expected %b",
                                                  m_tuser[0], want.dec));
                end
            end
            // Watchdog on cycles with no transfer on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired at %0t", $realtime);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge aclk) begin
        logic        nv;
        cipher_req_t cur;
        if (aresetn && (!s_tvalid || in_taken)) begin
            in_taken = 1'b0;
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                s_tdata <= {cur.val, cur.idx, cur.word};
                s_tuser <= cur.cmd;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            s_tvalid <= nv;
        end
    end

    // Receiver: stall pattern that changes mode every window
    int win_left = 0;
    int rx_mode  = 0;
    int rx_count = 0;
    always @(negedge aclk) begin
        logic rdy;
        if (win_left == 0) begin
            win_left = $urandom_range(16, 160);
            rx_mode  = $urandom_range(0, 3);
        end
        win_left--;
        rx_count++;
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ((rx_count % 24) < 6);
        endcase
        m_tready <= rdy;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(0, 63);
            3:       return ~(64'h1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_req(input logic [1:0] cmd, input logic [63:0] word,
                            input logic [7:0] idx, input logic [7:0] val);
        pending_q.push_back('{cmd: cmd, word: word, idx: idx, val: val});
    endtask

    task automatic push_random_req();
        logic [7:0] idx;
        logic [7:0] val;
        idx = 8'($urandom);
        val = 8'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            // Reload a table entry, now and then at an extreme address or value
            if ($urandom_range(0, 9) == 0)
                idx = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 9) == 0)
                val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            push_req($urandom_range(0, 1) ? CMD_LOAD_SECOND : CMD_LOAD_FIRST,
                     {$urandom, $urandom}, idx, val);
        end else begin
            push_req($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, rand_word(), idx, val);
        end
    endtask

    // Wait until every transfer is done and the chain has emptied
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_offsets(input logic [31:0] l, input logic [31:0] r);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEFT_OFFSET;
        cfg_wdata <= l;
        @(negedge aclk);
        cfg_index <= CFG_RIGHT_OFFSET;
        cfg_wdata <= r;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        left_off  = l;
        right_off = r;
    endtask

    initial begin
        logic [31:0] offs_l [5];
        logic [31:0] offs_r [5];
        for (int i = 0; i < SBOX_DEPTH; i++) begin
            box_first[i]  = '0;
            box_second[i] = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // Fill both tables so that no lookup ever hits an unwritten entry
        for (int i = 0; i < SBOX_DEPTH; i++) begin
            push_req(CMD_LOAD_FIRST, '0, i[7:0], 8'($urandom));
            push_req(CMD_LOAD_SECOND, '0, i[7:0], 8'($urandom));
        end

        // Directed: table extremes, word extremes, both ways, ignored fields
        push_req(CMD_LOAD_FIRST, '1, 8'h00, 8'hFF);
        push_req(CMD_LOAD_SECOND, '1, 8'hFF, 8'h00);
        push_req(CMD_LOAD_FIRST, '0, 8'hFF, 8'h00);
        push_req(CMD_LOAD_SECOND, 64'hA5A5_5A5A_0F0F_F0F0, 8'h00, 8'hFF);
        push_req(CMD_ENCRYPT, 64'h0, 8'h00, 8'h00);
        push_req(CMD_DECRYPT, 64'h0, 8'h00, 8'h00);
        push_req(CMD_ENCRYPT, '1, 8'hFF, 8'hFF);
        push_req(CMD_DECRYPT, '1, 8'hFF, 8'hFF);
        push_req(CMD_ENCRYPT, 64'h0000_0001_0000_0001, 8'h55, 8'hAA);
        push_req(CMD_DECRYPT, 64'h8000_0000_8000_0000, 8'hAA, 8'h55);
        push_req(CMD_ENCRYPT, 64'hFFFF_FFFF_0000_0000, 8'h01, 8'h80);
        push_req(CMD_DECRYPT, 64'h0000_0000_FFFF_FFFF, 8'h80, 8'h01);
        push_req(CMD_ENCRYPT, 64'h5555_5555_5555_5555, 8'h00, 8'h00);
        push_req(CMD_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00, 8'h00);
        push_req(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF, 8'h12, 8'h34);
        push_req(CMD_DECRYPT, 64'h0123_4567_89AB_CDEF, 8'h12, 8'h34);
        push_req(CMD_LOAD_FIRST, 64'h0123_4567_89AB_CDEF, 8'h00, 8'h00);
        push_req(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF, 8'h00, 8'h00);

        // Offset settings per phase: reset values first, then extremes and random
        offs_l[0] = 32'h0;         offs_r[0] = 32'h0;
        offs_l[1] = 32'hFFFF_FFFF; offs_r[1] = 32'hFFFF_FFFF;
        offs_l[2] = $urandom;      offs_r[2] = $urandom;
        offs_l[3] = 32'h0;         offs_r[3] = 32'hFFFF_FFFF;
        offs_l[4] = $urandom;      offs_r[4] = 32'h0;

        for (int p = 0; p < 5; p++) begin
            if (p != 0) begin
                wait_drained();
                write_offsets(offs_l[p], offs_r[p]);
                @(posedge aclk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_req();
        end

        wait_drained();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
